// ===== rtl/msgv_pkg.sv =====
// ----------------------------------------------------------------------------
// msgv_pkg
// Shared types, opcodes and format bytes of the MessagePack value encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package msgv_pkg;

   localparam int REQ_DATA_W  = 96;
   localparam int RSP_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int MAX_BYTES   = 9;
   localparam int COUNT_W     = 4;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [3:0] {
      OP_UINT    = 4'd0,
      OP_INT     = 4'd1,
      OP_NIL     = 4'd2,
      OP_BOOL    = 4'd3,
      OP_ARRAY   = 4'd4,
      OP_MAP     = 4'd5,
      OP_FLOAT64 = 4'd6,
      OP_BIN     = 4'd7,
      OP_STR     = 4'd8,
      OP_PAYLOAD = 4'd9,
      OP_RESTART = 4'd10
   } op_type;

   localparam logic [7:0] MP_NIL      = 8'hc0;
   localparam logic [7:0] MP_FALSE    = 8'hc2;
   localparam logic [7:0] MP_FIXARRAY = 8'h90;
   localparam logic [7:0] MP_ARRAY16  = 8'hdc;
   localparam logic [7:0] MP_FIXMAP   = 8'h80;
   localparam logic [7:0] MP_MAP16    = 8'hde;
   localparam logic [7:0] MP_FLOAT64  = 8'hcb;
   localparam logic [7:0] MP_BIN8     = 8'hc4;
   localparam logic [7:0] MP_BIN16    = 8'hc5;
   localparam logic [7:0] MP_STR8     = 8'hd9;
   localparam logic [7:0] MP_FIXSTR   = 8'ha0;
   localparam logic [7:0] MP_UINT8    = 8'hcc;
   localparam logic [7:0] MP_UINT16   = 8'hcd;
   localparam logic [7:0] MP_UINT32   = 8'hce;
   localparam logic [7:0] MP_INT8     = 8'hd0;
   localparam logic [7:0] MP_INT16    = 8'hd1;
   localparam logic [7:0] MP_INT32    = 8'hd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_BUFFER_CAPACITY = 3'd0;

   // one encoded item: bytes in emit order, bytes[0] goes first
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [COUNT_W-1:0]        count;
      logic                      error;
      logic [15:0]               base;
   } entry_type;

endpackage

`default_nettype wire

// ===== rtl/msgpack_value_encoder.sv =====
// ----------------------------------------------------------------------------
// msgpack_value_encoder
// Encodes typed values and payload bytes into a MessagePack byte stream,
// tracking fill level against a capacity register with a sticky error.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              content
//  req_     in   tvalid/tready          tuser op, tdata value/length/byte
//  rsp_     out  tvalid/tready/tlast    tdata byte/error/fill level
//  csr_     in   apb write/read         buffer_capacity, read at address 0, written at 0 to 3
//
//  the encoder takes one word per cycle while the item queue has room
//  the serializer sends one byte per cycle unless rsp_ stalls; an item holds
//  at most nine bytes, which is what a float64 needs
//  words that store no byte (restart, errors, dropped payload) push no item
//  reset is synchronous and clears position, error, payload and queue
//  a stalled rsp_ side backs up into the queue, then drops req_tready
// ----------------------------------------------------------------------------
`default_nettype none

module msgpack_value_encoder #(
   parameter int QueueDepth = msgv_pkg::QUEUE_DEPTH
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   // [63:0] value, [83:64] length, [91:84] payload_byte, [95:92] zero
   input  wire  [msgv_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [3:0] op
   input  wire  [3:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // [7:0] out_byte, [8] error_flag, [24:9] fill_level, [31:25] zero
   output logic [msgv_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire  [msgv_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire  [msgv_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [msgv_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import msgv_pkg::*;

   logic [15:0] capacity_ff;
   logic        queue_full;
   logic        push_valid;
   entry_type   push_entry;
   logic        head_valid;
   entry_type   head_entry;
   logic        pop;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_BUFFER_CAPACITY) ? {16'd0, capacity_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= 16'hffff;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[CSR_ADDR_W-1:2] == CSR_BUFFER_CAPACITY[CSR_ADDR_W-1:2]) begin
         capacity_ff <= csr_pwdata[15:0];
      end
   end

   msgv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .capacity   (capacity_ff),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   msgv_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   msgv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== rtl/msgv_front.sv =====
// ----------------------------------------------------------------------------
// msgv_front
// Accepts request words, encodes them and keeps write position, error and
// the open payload; pushes the bytes that fit into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module msgv_front (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [msgv_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire  [3:0]                         req_tuser,
   input  wire  [15:0]                        capacity,
   input  wire                                queue_full,
   output logic                               push_valid,
   output msgv_pkg::entry_type                push_entry
);
   import msgv_pkg::*;

   logic [15:0] wp_ff, wp_in;
   logic        err_ff, err_in;
   logic [15:0] left_ff, left_in;
   logic        drop_ff, drop_in;

   logic [63:0] value;
   logic [19:0] len;
   logic [7:0]  pbyte;
   logic [31:0] v32;
   logic        accept;

   logic [MAX_BYTES-1:0][7:0] enc;
   logic [COUNT_W-1:0]        n;
   logic                      enc_err;
   logic                      opening;
   logic                      interrupt;
   logic [15:0]               avail;
   logic [COUNT_W-1:0]        stored;
   logic [15:0]               wp_new;
   logic                      too_big;

   assign value = req_tdata[63:0];
   assign len   = req_tdata[83:64];
   assign pbyte = req_tdata[91:84];
   assign v32   = value[31:0];

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      enc       = '0;
      n         = '0;
      enc_err   = 1'b0;
      opening   = 1'b0;
      interrupt = (req_tuser <= 4'(OP_STR)) && (left_ff != 16'd0);
      unique case (op_type'(req_tuser))
         OP_UINT, OP_INT: begin
            if (!v32[31] || op_type'(req_tuser) == OP_UINT) begin
               if (v32 < 32'd128) begin
                  enc[0] = v32[7:0]; n = 4'd1;
               end else if (v32 < 32'd256) begin
                  enc[0] = MP_UINT8; enc[1] = v32[7:0]; n = 4'd2;
               end else if (v32 < 32'd65536) begin
                  enc[0] = MP_UINT16; enc[1] = v32[15:8]; enc[2] = v32[7:0]; n = 4'd3;
               end else begin
                  enc[0] = MP_UINT32; enc[1] = v32[31:24]; enc[2] = v32[23:16];
                  enc[3] = v32[15:8]; enc[4] = v32[7:0]; n = 4'd5;
               end
            end else if (v32 >= 32'hffffffe0) begin
               enc[0] = v32[7:0]; n = 4'd1;
            end else if (v32 >= 32'hffffff80) begin
               enc[0] = MP_INT8; enc[1] = v32[7:0]; n = 4'd2;
            end else if (v32 >= 32'hffff8000) begin
               enc[0] = MP_INT16; enc[1] = v32[15:8]; enc[2] = v32[7:0]; n = 4'd3;
            end else begin
               enc[0] = MP_INT32; enc[1] = v32[31:24]; enc[2] = v32[23:16];
               enc[3] = v32[15:8]; enc[4] = v32[7:0]; n = 4'd5;
            end
         end
         OP_NIL: begin
            enc[0] = MP_NIL; n = 4'd1;
         end
         OP_BOOL: begin
            enc[0] = MP_FALSE | {7'd0, value[0]}; n = 4'd1;
         end
         OP_ARRAY, OP_MAP: begin
            if (len > 20'd65535) begin
               enc_err = 1'b1;
            end else if (len <= 20'd15) begin
               enc[0] = ((op_type'(req_tuser) == OP_ARRAY) ? MP_FIXARRAY : MP_FIXMAP)
                        | {4'd0, len[3:0]};
               n = 4'd1;
            end else begin
               enc[0] = (op_type'(req_tuser) == OP_ARRAY) ? MP_ARRAY16 : MP_MAP16;
               enc[1] = len[15:8]; enc[2] = len[7:0]; n = 4'd3;
            end
         end
         OP_FLOAT64: begin
            enc[0] = MP_FLOAT64;
            for (int k = 0; k < 8; k++) begin
               enc[k+1] = value[8*(7-k) +: 8];
            end
            n = 4'd9;
         end
         OP_BIN: begin
            if (len > 20'd65535) begin
               enc_err = 1'b1;
            end else if (len < 20'd256) begin
               enc[0] = MP_BIN8; enc[1] = len[7:0]; n = 4'd2; opening = 1'b1;
            end else begin
               enc[0] = MP_BIN16; enc[1] = len[15:8]; enc[2] = len[7:0];
               n = 4'd3; opening = 1'b1;
            end
         end
         OP_STR: begin
            if (len > 20'd255) begin
               enc_err = 1'b1;
            end else if (len < 20'd32) begin
               enc[0] = MP_FIXSTR | {3'd0, len[4:0]}; n = 4'd1; opening = 1'b1;
            end else begin
               enc[0] = MP_STR8; enc[1] = len[7:0]; n = 4'd2; opening = 1'b1;
            end
         end
         OP_PAYLOAD: begin
            // stray byte with no open payload is flagged below
            if (left_ff != 16'd0 && !drop_ff) begin
               enc[0] = pbyte; n = 4'd1;
            end
         end
         default: begin
         end
      endcase
   end

   // bytes that still fit form a prefix of the encoding
   always_comb begin
      avail   = (wp_ff >= capacity) ? 16'd0 : capacity - wp_ff;
      stored  = ({12'd0, n} < avail) ? n : avail[COUNT_W-1:0];
      wp_new  = wp_ff + {12'd0, stored};
      too_big = ({1'b0, wp_new} + {1'b0, len[15:0]}) > {1'b0, capacity};
   end

   always_comb begin
      wp_in   = wp_ff;
      err_in  = err_ff;
      left_in = left_ff;
      drop_in = drop_ff;
      if (accept) begin
         priority if (req_tuser == 4'(OP_RESTART)) begin
            wp_in   = 16'd0;
            err_in  = 1'b0;
            left_in = 16'd0;
            drop_in = 1'b0;
         end else if (req_tuser == 4'(OP_PAYLOAD)) begin
            wp_in = wp_new;
            if (left_ff == 16'd0) begin
               err_in = 1'b1;
            end else begin
               left_in = left_ff - 16'd1;
               if (left_ff == 16'd1) begin
                  drop_in = 1'b0;
               end
               if (stored != n) begin
                  err_in = 1'b1;
               end
            end
         end else if (req_tuser <= 4'(OP_STR)) begin
            wp_in  = wp_new;
            err_in = err_ff | interrupt | enc_err | (stored != n);
            if (interrupt) begin
               left_in = 16'd0;
               drop_in = 1'b0;
            end
            if (opening) begin
               left_in = len[15:0];
               drop_in = too_big;
               if (too_big) begin
                  err_in = 1'b1;
               end
            end
         end else begin
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= 16'd0;
         err_ff  <= 1'b0;
         left_ff <= 16'd0;
         drop_ff <= 1'b0;
      end else begin
         wp_ff   <= wp_in;
         err_ff  <= err_in;
         left_ff <= left_in;
         drop_ff <= drop_in;
      end
   end

   assign push_valid       = accept && (stored != '0);
   assign push_entry.bytes = enc;
   assign push_entry.count = stored;
   assign push_entry.error = err_ff | interrupt;
   assign push_entry.base  = wp_ff;

endmodule

`default_nettype wire

// ===== rtl/msgv_queue.sv =====
// ----------------------------------------------------------------------------
// msgv_queue
// Short queue of encoded items between the encoder and the byte serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module msgv_queue #(
   parameter int Depth = msgv_pkg::QUEUE_DEPTH
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push_valid,
   input  msgv_pkg::entry_type  push_entry,
   output logic                 full,
   output logic                 head_valid,
   output msgv_pkg::entry_type  head_entry,
   input  wire                  pop
);
   import msgv_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   entry_type            slots_ff [Depth];
   logic [PtrW-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]      count_ff;
   logic                 do_push, do_pop;

   assign full       = (count_ff == CntW'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_entry = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CntW'(do_push) - CntW'(do_pop);
      end
   end

endmodule

`default_nettype wire

// ===== rtl/msgv_back.sv =====
// ----------------------------------------------------------------------------
// msgv_back
// Walks the head item one byte per cycle, unless the output stalls, into the response output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msgv_back (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               head_valid,
   input  msgv_pkg::entry_type               head_entry,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [msgv_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);
   import msgv_pkg::*;

   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic               valid_ff;
   logic [7:0]         byte_ff;
   logic               last_ff;
   logic               err_ff;
   logic [15:0]        fill_ff;
   logic               load;
   logic               is_last;

   assign load    = head_valid && (!valid_ff || rsp_tready);
   assign is_last = (idx_ff == head_entry.count - 1'b1);
   assign pop     = load && is_last;
   assign idx_in  = is_last ? '0 : idx_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= idx_in;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= head_entry.bytes[idx_ff];
         last_ff <= is_last;
         err_ff  <= head_entry.error;
         fill_ff <= head_entry.base + {12'd0, idx_ff} + 16'd1;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {7'd0, fill_ff, err_ff, byte_ff};

endmodule

`default_nettype wire

// ===== rtl/msgv_checker.sv =====
// ----------------------------------------------------------------------------
// msgv_checker
// Port-level checks on the response stream of the encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module msgv_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              rsp_tvalid,
   input wire                              rsp_tready,
   input wire [msgv_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input wire                              rsp_tlast
);

   // bytes of one item leave without gaps and count up by one
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=>
         (rsp_tvalid && rsp_tdata[24:9] == $past(rsp_tdata[24:9]) + 16'd1))
      else $error("fill level did not advance within an item");

   a_fill_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[24:9] != 16'd0))
      else $error("stored word with zero fill level");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled response word changed");

endmodule

bind msgpack_value_encoder msgv_checker u_msgv_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ===== tb/sv/msgv_checker.sv =====
// ----------------------------------------------------------------------------
// msgv_scoreboard
// Watches the req_, rsp_ and csr_ ports of the MessagePack value encoder,
// predicts the byte stream each accepted request word should produce and
// compares every accepted response word against it in order.
// ----------------------------------------------------------------------------
`default_nettype none

module msgv_scoreboard (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   input  wire                              req_tready,
   // [63:0] value, [83:64] length, [91:84] payload_byte, [95:92] zero
   input  wire  [msgv_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [3:0] op
   input  wire  [3:0]                       req_tuser,
   input  wire                              rsp_tvalid,
   input  wire                              rsp_tready,
   // [7:0] out_byte, [8] error_flag, [24:9] fill_level, [31:25] zero
   input  wire  [msgv_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  wire                              rsp_tlast,
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire  [msgv_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire  [msgv_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   input  wire  [msgv_pkg::CSR_DATA_W-1:0]  csr_prdata,
   input  wire                              csr_pready,
   output int                               mismatch_count,
   output int                               bytes_pending
);

   timeunit 1ns;
   timeprecision 1ps;

   import msgv_pkg::*;

   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic        err;
      logic [15:0] fill;
   } stored_byte_type;

   stored_byte_type expected_bytes[$];

   logic [15:0] buf_capacity;
   logic [15:0] write_pos;
   logic        error_sticky;
   logic [15:0] payload_owed;
   logic        payload_skip;

   task automatic store_byte(input logic [7:0] b);
      stored_byte_type e;
      if (write_pos >= buf_capacity) begin
         error_sticky = 1'b1;
      end else begin
         write_pos = write_pos + 16'd1;
         e.data = b;
         e.last = 1'b0;
         e.err  = error_sticky;
         e.fill = write_pos;
         expected_bytes.push_back(e);
      end
   endtask

   task automatic store_be(input logic [63:0] v, input int nbytes);
      for (int i = nbytes - 1; i >= 0; i--) store_byte(v[8*i +: 8]);
   endtask

   task automatic encode_uint(input logic [31:0] v);
      if (v < 32'd128) begin
         store_byte(v[7:0]);
      end else if (v < 32'd256) begin
         store_byte(MP_UINT8);
         store_byte(v[7:0]);
      end else if (v < 32'd65536) begin
         store_byte(MP_UINT16);
         store_be({32'd0, v}, 2);
      end else begin
         store_byte(MP_UINT32);
         store_be({32'd0, v}, 4);
      end
   endtask

   task automatic encode_int(input logic [31:0] v);
      if (!v[31]) begin
         encode_uint(v);
      end else if (v >= 32'hffff_ffe0) begin
         store_byte(v[7:0]);
      end else if (v >= 32'hffff_ff80) begin
         store_byte(MP_INT8);
         store_byte(v[7:0]);
      end else if (v >= 32'hffff_8000) begin
         store_byte(MP_INT16);
         store_be({32'd0, v}, 2);
      end else begin
         store_byte(MP_INT32);
         store_be({32'd0, v}, 4);
      end
   endtask

   task automatic encode_count(input logic [19:0] len, input logic [7:0] fix,
                               input logic [7:0] wide);
      if (len > 20'd65535) begin
         error_sticky = 1'b1;
      end else if (len <= 20'd15) begin
         store_byte(fix | {4'd0, len[3:0]});
      end else begin
         store_byte(wide);
         store_be({44'd0, len}, 2);
      end
   endtask

   // the header is already stored; the whole payload goes or none of it
   task automatic open_payload(input logic [19:0] len);
      payload_owed = len[15:0];
      payload_skip = 1'b0;
      if ({16'd0, write_pos} + {12'd0, len} > {16'd0, buf_capacity}) begin
         error_sticky = 1'b1;
         payload_skip = 1'b1;
      end
   endtask

   task automatic predict_encoding(input logic [3:0] op, input logic [63:0] value,
                                   input logic [19:0] len, input logic [7:0] pbyte);
      int first;
      stored_byte_type e;
      first = expected_bytes.size();
      if (op == OP_RESTART) begin
         write_pos    = 16'd0;
         error_sticky = 1'b0;
         payload_owed = 16'd0;
         payload_skip = 1'b0;
      end else if (op == OP_PAYLOAD) begin
         if (payload_owed == 16'd0) begin
            error_sticky = 1'b1;
         end else begin
            payload_owed = payload_owed - 16'd1;
            if (!payload_skip) store_byte(pbyte);
            if (payload_owed == 16'd0) payload_skip = 1'b0;
         end
      end else if (op < OP_PAYLOAD) begin
         // a new value abandons whatever payload was still owed
         if (payload_owed != 16'd0) begin
            error_sticky = 1'b1;
            payload_owed = 16'd0;
            payload_skip = 1'b0;
         end
         case (op)
            OP_UINT:    encode_uint(value[31:0]);
            OP_INT:     encode_int(value[31:0]);
            OP_NIL:     store_byte(MP_NIL);
            OP_BOOL:    store_byte({MP_FALSE[7:1], value[0]});
            OP_ARRAY:   encode_count(len, MP_FIXARRAY, MP_ARRAY16);
            OP_MAP:     encode_count(len, MP_FIXMAP, MP_MAP16);
            OP_FLOAT64: begin
               store_byte(MP_FLOAT64);
               store_be(value, 8);
            end
            OP_BIN: begin
               if (len > 20'd65535) begin
                  error_sticky = 1'b1;
               end else begin
                  if (len < 20'd256) begin
                     store_byte(MP_BIN8);
                     store_byte(len[7:0]);
                  end else begin
                     store_byte(MP_BIN16);
                     store_be({44'd0, len}, 2);
                  end
                  open_payload(len);
               end
            end
            OP_STR: begin
               if (len > 20'd255) begin
                  error_sticky = 1'b1;
               end else begin
                  if (len < 20'd32) begin
                     store_byte(MP_FIXSTR | {3'd0, len[4:0]});
                  end else begin
                     store_byte(MP_STR8);
                     store_byte(len[7:0]);
                  end
                  open_payload(len);
               end
            end
            default: ;
         endcase
      end
      // ops above restart are ignored
      if (expected_bytes.size() > first) begin
         e = expected_bytes[expected_bytes.size() - 1];
         e.last = 1'b1;
         expected_bytes[expected_bytes.size() - 1] = e;
      end
   endtask

   always @(posedge clock) begin
      stored_byte_type e;
      if (reset) begin
         buf_capacity   = 16'hffff;
         write_pos      = 16'd0;
         error_sticky   = 1'b0;
         payload_owed   = 16'd0;
         payload_skip   = 1'b0;
         mismatch_count = 0;
         expected_bytes.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr == CSR_BUFFER_CAPACITY) begin
            if (csr_pwrite) begin
               buf_capacity = csr_pwdata[15:0];
            end else if (csr_prdata !== {16'd0, buf_capacity}) begin
               mismatch_count++;
               $display("%0t: capacity read expected %08h got %08h", $time,
                        {16'd0, buf_capacity}, csr_prdata);
            end
         end
         if (req_tvalid && req_tready)
            predict_encoding(req_tuser, req_tdata[63:0], req_tdata[83:64], req_tdata[91:84]);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               mismatch_count++;
               $display("%0t: expected no word, got data=%02h last=%0b err=%0b fill=%0d",
                        $time, rsp_tdata[7:0], rsp_tlast, rsp_tdata[8], rsp_tdata[24:9]);
            end else begin
               e = expected_bytes.pop_front();
               if (rsp_tdata[7:0] !== e.data || rsp_tlast !== e.last ||
                   rsp_tdata[8] !== e.err || rsp_tdata[24:9] !== e.fill) begin
                  mismatch_count++;
                  $display("%0t: expected data=%02h last=%0b err=%0b fill=%0d, got data=%02h last=%0b err=%0b fill=%0d",
                           $time, e.data, e.last, e.err, e.fill, rsp_tdata[7:0],
                           rsp_tlast, rsp_tdata[8], rsp_tdata[24:9]);
               end
            end
         end
      end
      bytes_pending <= expected_bytes.size();
   end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives typed values, payload bytes and capacity writes into the MessagePack
// value encoder under varying idle and stall patterns; msgv_scoreboard
// predicts and compares the encoded byte stream.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import msgv_pkg::*;

   localparam int DRAIN_CYCLES = 40;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic [3:0]            req_tuser   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int mismatch_count;
   int bytes_pending;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int rsp_hold_len   = 0;
   int words_sent     = 0;

   always #4 clock = ~clock;

   msgpack_value_encoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   msgv_scoreboard u_scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .bytes_pending  (bytes_pending)
   );

   // receiver: random stalls, plus a long hold-off when one is requested
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_len != 0) begin
            hold_left    = rsp_hold_len;
            rsp_hold_len = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_word(input logic [3:0] op, input logic [63:0] value,
                            input logic [19:0] len, input logic [7:0] pbyte);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'd0, pbyte, len, value};
      do @(posedge clock); while (!req_tready);
      if (op <= OP_RESTART) words_sent++;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic csr_access(input logic write, input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= CSR_BUFFER_CAPACITY;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_capacity(input logic [15:0] cap);
      csr_access(1'b1, {16'd0, cap});
      @(posedge clock);
      csr_access(1'b0, '0);
   endtask

   // block must be idle before the capacity moves
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (bytes_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [19:0] pick_count_length();
      int sel;
      sel = $urandom_range(9);
      if (sel < 5) return 20'($urandom_range(15));
      if (sel < 9) return 20'($urandom_range(65535, 16));
      return 20'($urandom_range(20'hfffff, 65536));
   endfunction

   task automatic send_random_item();
      int          pick;
      int          sent;
      logic [31:0] v;
      logic [19:0] len;
      logic [3:0]  op;
      pick = $urandom_range(99);
      if (pick < 6) begin
         send_word(OP_RESTART, rand64(), 20'($urandom), 8'($urandom));
      end else if (pick < 10) begin
         send_word(4'($urandom_range(15)), rand64(), 20'($urandom), 8'($urandom));
      end else if (pick < 16) begin
         op = $urandom_range(1) ? OP_ARRAY : OP_MAP;
         send_word(op, rand64(), pick_count_length(), 8'($urandom));
      end else if (pick < 34) begin
         v = $urandom >> $urandom_range(31);
         send_word(OP_UINT, {$urandom, v}, 20'($urandom), 8'($urandom));
      end else if (pick < 52) begin
         v = $urandom >> $urandom_range(31);
         if ($urandom_range(1)) v = -v;
         send_word(OP_INT, {$urandom, v}, 20'($urandom), 8'($urandom));
      end else if (pick < 57) begin
         send_word(OP_NIL, rand64(), 20'($urandom), 8'($urandom));
      end else if (pick < 62) begin
         send_word(OP_BOOL, rand64(), 20'($urandom), 8'($urandom));
      end else if (pick < 72) begin
         send_word(OP_FLOAT64, rand64(), 20'($urandom), 8'($urandom));
      end else begin
         // header followed by its payload, sometimes cut short or overrun
         op = $urandom_range(1) ? OP_BIN : OP_STR;
         sel_len: begin
            pick = $urandom_range(99);
            if (pick < 80) len = 20'($urandom_range(12));
            else if (pick < 95) len = 20'($urandom_range(60, 13));
            else if (op == OP_BIN) len = 20'($urandom_range(20'hfffff, 65536));
            else len = 20'($urandom_range(20'hfffff, 256));
         end
         send_word(op, rand64(), len, 8'($urandom));
         sent = (len > 20'd255) ? 0 : int'(len);
         pick = $urandom_range(99);
         if (pick < 12) sent = $urandom_range(sent);
         else if (pick < 17) sent = sent + 1;
         for (int i = 0; i < sent; i++)
            send_word(OP_PAYLOAD, rand64(), 20'($urandom), 8'($urandom));
      end
   endtask

   task automatic run_random(input int count);
      int target;
      target = words_sent + count;
      while (words_sent < target) send_random_item();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: encoding boundaries and error cases at full capacity
      send_word(OP_UINT, 64'd0, 20'd0, 8'd0);
      send_word(OP_UINT, 64'hffff_ffff_0000_007f, 20'hfffff, 8'hff);
      send_word(OP_UINT, 64'd128, 20'd0, 8'd0);
      send_word(OP_UINT, 64'd65535, 20'd0, 8'd0);
      send_word(OP_UINT, 64'h0000_0000_ffff_ffff, 20'd0, 8'd0);
      send_word(OP_INT, 64'h0000_0000_ffff_ffff, 20'd0, 8'd0);
      send_word(OP_INT, 64'h0000_0000_ffff_ffdf, 20'd0, 8'd0);
      send_word(OP_INT, 64'h0000_0000_ffff_ff7f, 20'd0, 8'd0);
      send_word(OP_INT, 64'h0000_0000_ffff_7fff, 20'd0, 8'd0);
      send_word(OP_INT, 64'h0000_0000_8000_0000, 20'd0, 8'd0);
      send_word(OP_INT, 64'hffff_ffff_7fff_ffff, 20'd0, 8'd0);
      send_word(OP_NIL, 64'd0, 20'd0, 8'd0);
      send_word(OP_BOOL, 64'hffff_ffff_ffff_fffe, 20'd0, 8'd0);
      send_word(OP_BOOL, 64'd1, 20'd0, 8'd0);
      send_word(OP_ARRAY, 64'd0, 20'd15, 8'd0);
      send_word(OP_ARRAY, 64'd0, 20'd65535, 8'd0);
      send_word(OP_MAP, 64'd0, 20'd16, 8'd0);
      send_word(OP_MAP, 64'd0, 20'd65536, 8'd0);
      send_word(OP_FLOAT64, 64'h8000_0000_0000_0001, 20'd0, 8'd0);
      send_word(OP_BIN, 64'd0, 20'd2, 8'd0);
      send_word(OP_PAYLOAD, 64'd0, 20'd0, 8'h00);
      send_word(OP_PAYLOAD, 64'd0, 20'd0, 8'hff);
      send_word(OP_BIN, 64'd0, 20'd300, 8'd0);
      send_word(OP_PAYLOAD, 64'd0, 20'd0, 8'h5a);
      send_word(OP_STR, 64'd0, 20'd31, 8'd0);
      send_word(OP_NIL, 64'd0, 20'd0, 8'd0);
      send_word(OP_PAYLOAD, 64'd0, 20'd0, 8'h11);
      send_word(OP_STR, 64'd0, 20'd40, 8'd0);
      send_word(OP_RESTART, 64'd0, 20'd0, 8'd0);
      send_word(OP_STR, 64'd0, 20'd256, 8'd0);
      send_word(OP_BIN, 64'd0, 20'hfffff, 8'd0);
      send_word(4'd13, 64'd0, 20'd0, 8'd0);
      send_word(OP_NIL, 64'd0, 20'd0, 8'd0);

      // empty buffer: everything is dropped
      wait_drain();
      set_capacity(16'd0);
      send_word(OP_NIL, 64'd0, 20'd0, 8'd0);
      send_word(OP_BIN, 64'd0, 20'd0, 8'd0);
      send_word(OP_STR, 64'd0, 20'd3, 8'd0);
      repeat (3) send_word(OP_PAYLOAD, 64'd0, 20'd0, 8'h77);
      send_word(OP_RESTART, 64'd0, 20'd0, 8'd0);

      // payload that exactly fills the buffer, then one byte too many
      wait_drain();
      set_capacity(16'd5);
      send_word(OP_STR, 64'd0, 20'd4, 8'd0);
      repeat (4) send_word(OP_PAYLOAD, 64'd0, 20'd0, 8'($urandom));
      send_word(OP_UINT, 64'd1, 20'd0, 8'd0);
      send_word(OP_RESTART, 64'd0, 20'd0, 8'd0);

      wait_drain();
      set_capacity(16'hffff);
      run_random(70);

      // long receiver hold-off while floats keep coming, then let it drain
      rsp_hold_len = 300;
      repeat (16) send_word(OP_FLOAT64, rand64(), 20'($urandom), 8'($urandom));
      wait_drain();

      set_capacity(16'd40);
      send_idle_pct = 72;
      run_random(60);

      wait_drain();
      set_capacity(16'd1);
      send_idle_pct  = 0;
      recv_stall_pct = 72;
      run_random(20);

      wait_drain();
      set_capacity(16'($urandom_range(200, 16)));
      run_random(55);

      wait_drain();
      set_capacity(16'hffff);
      send_idle_pct  = 33;
      recv_stall_pct = 33;
      run_random(55);

      wait_drain();
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire
